// ===== hdl/pf25519_pkg.sv =====
// Shared types and constants for the GF(2^255-19) arithmetic unit.
// No dependencies; used by pf25519_reduce and prime_field_25519_alu.
`default_nettype none

package pf25519_pkg;

   // Operand and internal widths.
   localparam int unsigned LIMB_W    = 32;
   localparam int unsigned NUM_LIMBS = 8;
   localparam int unsigned FIELD_W   = 256;
   localparam int unsigned NUM_COLS  = 2 * NUM_LIMBS - 1;
   localparam int unsigned HALF_W    = 66;
   localparam int unsigned COL_W     = 67;
   localparam int unsigned RED_W     = 75;
   localparam int unsigned SUM_W     = 300;

   // The modulus p = 2^255 - 19 and 4p, used to keep a subtraction non-negative.
   localparam logic [254:0]       PRIME    = {{247{1'b1}}, 8'hED};
   localparam logic [SUM_W-1:0]   PRIME_X4 = {43'd0, PRIME, 2'b00};

   // Fold factors: 2^256 = 38 and 2^255 = 19 modulo p.
   localparam logic [5:0] FOLD_256 = 6'd38;
   localparam logic [4:0] FOLD_255 = 5'd19;

   // Operation codes.
   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_SQR = 2'd3
   } mode_type;

   // Pipeline control handed from one section to the next.
   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/pf25519_reduce.sv =====
// Final reduction pipeline: folds a 300-bit sum down to the canonical residue mod p.
// Depends on pf25519_pkg.
`default_nettype none

module pf25519_reduce (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pf25519_pkg::stage_ctrl_type     ctrl,
   input  wire logic [pf25519_pkg::SUM_W-1:0]   sum_in,
   output logic                                 out_valid,
   output logic [254:0]                         result
);

   logic         w_valid_ff, x_valid_ff, y_valid_ff, r_valid_ff;
   logic [256:0] w_ff, w_in;
   logic [255:0] x_ff, x_in;
   logic [255:0] y_ff, y_in;
   logic [254:0] r_ff, r_in;
   logic [255:0] trial;

   // Fold the bits at 2^256 and above with the factor 38.
   assign w_in = {1'b0, sum_in[255:0]}
                 + (257'(sum_in[pf25519_pkg::SUM_W-1:256]) * 257'(pf25519_pkg::FOLD_256));

   // A remaining carry at 2^256 leaves a small low part, so one more fold closes it.
   assign x_in = w_ff[255:0] + (w_ff[256] ? 256'(pf25519_pkg::FOLD_256) : 256'd0);

   // Fold bit 255 with the factor 19.
   assign y_in = {1'b0, x_ff[254:0]} + (x_ff[255] ? 256'(pf25519_pkg::FOLD_255) : 256'd0);

   // One trial subtraction of p gives the canonical value.
   assign trial = y_ff - {1'b0, pf25519_pkg::PRIME};
   assign r_in  = (y_ff >= {1'b0, pf25519_pkg::PRIME}) ? trial[254:0] : y_ff[254:0];

   // Stage registers, all moving together when the pipeline advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         x_valid_ff <= 1'b0;
         y_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         w_valid_ff <= ctrl.valid;
         x_valid_ff <= w_valid_ff;
         y_valid_ff <= x_valid_ff;
         r_valid_ff <= y_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         w_ff <= w_in;
         x_ff <= x_in;
         y_ff <= y_in;
         r_ff <= r_in;
      end
   end

   assign out_valid = r_valid_ff;
   assign result    = r_ff;

   // A carry out of the first fold only occurs with a small low part.
   a_fold_small: assert property (@(posedge clock) disable iff (reset)
      (w_valid_ff && w_ff[256]) |-> (w_ff[255:51] == '0))
      else $error("first fold carried with a large remainder");

   // After the 19 fold the value is at most 2^255 + 18.
   a_fold_bound: assert property (@(posedge clock) disable iff (reset)
      (y_valid_ff && y_ff[255]) |-> (y_ff[254:0] < 255'd19))
      else $error("second fold exceeded its bound");

   // The delivered value is canonical.
   a_canonical: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff |-> (r_ff < pf25519_pkg::PRIME))
      else $error("result not below the modulus");

endmodule

`default_nettype wire

// ===== hdl/prime_field_25519_alu.sv =====
// Top level of the GF(2^255-19) add/subtract/multiply/square unit.
// Depends on pf25519_pkg and pf25519_reduce.
//
// The unit accepts one transaction per cycle while req_stall is low. A result,
// once presented, can be taken at the next edge.
// The path has ten register stages, set by the product pipeline: an input
// register, 64 parallel 32x32 multipliers, two column-sum stages, the
// factor-38 fold of the upper columns, a 300-bit three-way sum, and four
// reduction stages. A stall while a result is presented freezes the whole pipeline
// and is passed straight back as req_stall; no transaction is dropped or repeated.
`default_nettype none

module prime_field_25519_alu (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_mode,
   input  wire logic [63:0]  req_a_w0,
   input  wire logic [63:0]  req_a_w1,
   input  wire logic [63:0]  req_a_w2,
   input  wire logic [63:0]  req_a_w3,
   input  wire logic [63:0]  req_b_w0,
   input  wire logic [63:0]  req_b_w1,
   input  wire logic [63:0]  req_b_w2,
   input  wire logic [63:0]  req_b_w3,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [63:0]       rsp_result_w0,
   output logic [63:0]       rsp_result_w1,
   output logic [63:0]       rsp_result_w2,
   output logic [62:0]       rsp_result_w3
);

   localparam int unsigned LW = pf25519_pkg::LIMB_W;
   localparam int unsigned NL = pf25519_pkg::NUM_LIMBS;
   localparam int unsigned NC = pf25519_pkg::NUM_COLS;
   localparam int unsigned FW = pf25519_pkg::FIELD_W;
   localparam int unsigned SW = pf25519_pkg::SUM_W;
   localparam int unsigned RW = pf25519_pkg::RED_W;

   logic                        advance;
   pf25519_pkg::stage_ctrl_type reduce_ctrl;
   logic [254:0]                result;

   // Stage 1: operands.
   logic                    s1_valid_ff;
   pf25519_pkg::mode_type   s1_mode_ff;
   logic [FW-1:0]           s1_a_ff, s1_b_ff, a_in, b_in;

   // Stage 2: partial products.
   logic                    s2_valid_ff;
   pf25519_pkg::mode_type   s2_mode_ff;
   logic [FW-1:0]           s2_a_ff, s2_b_ff;
   logic [2*LW-1:0]         pp_ff [0:NL-1][0:NL-1];

   // Stage 3: half column sums.
   logic                    s3_valid_ff;
   pf25519_pkg::mode_type   s3_mode_ff;
   logic [FW-1:0]           s3_a_ff, s3_b_ff;
   logic [pf25519_pkg::HALF_W-1:0] col_a_ff [0:NC-1];
   logic [pf25519_pkg::HALF_W-1:0] col_b_ff [0:NC-1];
   logic [pf25519_pkg::HALF_W-1:0] col_a_in [0:NC-1];
   logic [pf25519_pkg::HALF_W-1:0] col_b_in [0:NC-1];

   // Stage 4: full column sums.
   logic                    s4_valid_ff;
   pf25519_pkg::mode_type   s4_mode_ff;
   logic [FW-1:0]           s4_a_ff, s4_b_ff;
   logic [pf25519_pkg::COL_W-1:0] col_ff [0:NC-1];

   // Stage 5: upper columns folded by 38.
   logic                    s5_valid_ff;
   pf25519_pkg::mode_type   s5_mode_ff;
   logic [FW-1:0]           s5_a_ff, s5_b_ff;
   logic [RW-1:0]           red_ff [0:NL-1];
   logic [RW-1:0]           red_in [0:NL-1];

   // Stage 6: 300-bit sum.
   logic                    s6_valid_ff;
   pf25519_pkg::mode_type   s6_mode_ff;
   logic [SW-1:0]           sum_ff, sum_in, g0, g1, g2;

   // The pipeline moves unless a finished result is being held.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Operand assembly; squaring uses a for both sides.
   assign a_in = {req_a_w3, req_a_w2, req_a_w1, req_a_w0};
   assign b_in = (pf25519_pkg::mode_type'(req_mode) == pf25519_pkg::MODE_SQR)
                 ? a_in : {req_b_w3, req_b_w2, req_b_w1, req_b_w0};

   // Column sums of the partial products, split by the a limb index.
   always_comb begin
      for (int k = 0; k < NC; k++) begin
         col_a_in[k] = '0;
         col_b_in[k] = '0;
      end
      for (int i = 0; i < NL; i++) begin
         for (int j = 0; j < NL; j++) begin
            if (i < NL / 2) begin
               col_a_in[4'(i + j)] = col_a_in[4'(i + j)]
                                     + pf25519_pkg::HALF_W'(pp_ff[i][j]);
            end else begin
               col_b_in[4'(i + j)] = col_b_in[4'(i + j)]
                                     + pf25519_pkg::HALF_W'(pp_ff[i][j]);
            end
         end
      end
   end

   // Fold column k+8 into column k: 38x = 32x + 4x + 2x.
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         red_in[k] = RW'(col_ff[k]);
         if (k + NL < NC) begin
            red_in[k] = red_in[k] + (RW'(col_ff[k + NL]) << 5)
                        + (RW'(col_ff[k + NL]) << 2) + (RW'(col_ff[k + NL]) << 1);
         end
      end
   end

   // Three non-overlapping groups of folded columns, or the add/subtract operands.
   always_comb begin
      case (s5_mode_ff)
         pf25519_pkg::MODE_ADD: begin
            g0 = SW'(s5_a_ff);
            g1 = SW'(s5_b_ff);
            g2 = '0;
         end
         pf25519_pkg::MODE_SUB: begin
            g0 = SW'(s5_a_ff);
            g1 = ~SW'(s5_b_ff);
            g2 = pf25519_pkg::PRIME_X4 + SW'(1);
         end
         default: begin
            g0 = SW'(red_ff[0]) | (SW'(red_ff[3]) << 96) | (SW'(red_ff[6]) << 192);
            g1 = (SW'(red_ff[1]) << 32) | (SW'(red_ff[4]) << 128)
                 | (SW'(red_ff[7]) << 224);
            g2 = (SW'(red_ff[2]) << 64) | (SW'(red_ff[5]) << 160);
         end
      endcase
   end

   assign sum_in = g0 + g1 + g2;

   // Valid bits of the front section.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Payload registers of the front section.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff <= pf25519_pkg::mode_type'(req_mode);
         s1_a_ff    <= a_in;
         s1_b_ff    <= b_in;

         s2_mode_ff <= s1_mode_ff;
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               pp_ff[i][j] <= s1_a_ff[LW*i +: LW] * s1_b_ff[LW*j +: LW];
            end
         end

         s3_mode_ff <= s2_mode_ff;
         s3_a_ff    <= s2_a_ff;
         s3_b_ff    <= s2_b_ff;
         for (int k = 0; k < NC; k++) begin
            col_a_ff[k] <= col_a_in[k];
            col_b_ff[k] <= col_b_in[k];
         end

         s4_mode_ff <= s3_mode_ff;
         s4_a_ff    <= s3_a_ff;
         s4_b_ff    <= s3_b_ff;
         for (int k = 0; k < NC; k++) begin
            col_ff[k] <= pf25519_pkg::COL_W'(col_a_ff[k])
                         + pf25519_pkg::COL_W'(col_b_ff[k]);
         end

         s5_mode_ff <= s4_mode_ff;
         s5_a_ff    <= s4_a_ff;
         s5_b_ff    <= s4_b_ff;
         for (int k = 0; k < NL; k++) begin
            red_ff[k] <= red_in[k];
         end

         s6_mode_ff <= s5_mode_ff;
         sum_ff     <= sum_in;
      end
   end

   // Reduction to the canonical residue and the result register.
   assign reduce_ctrl.advance = advance;
   assign reduce_ctrl.valid   = s6_valid_ff;

   pf25519_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (reduce_ctrl),
      .sum_in    (sum_ff),
      .out_valid (rsp_valid),
      .result    (result)
   );

   assign rsp_result_w0 = result[63:0];
   assign rsp_result_w1 = result[127:64];
   assign rsp_result_w2 = result[191:128];
   assign rsp_result_w3 = result[254:192];

   // No result is presented right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Squaring duplicates operand a.
   a_square_copy: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_mode_ff == pf25519_pkg::MODE_SQR) |-> (s1_b_ff == s1_a_ff))
      else $error("square operand mismatch");

   // Add and subtract sums stay below 2^258.
   a_addsub_range: assert property (@(posedge clock) disable iff (reset)
      (s6_valid_ff && (s6_mode_ff == pf25519_pkg::MODE_ADD
                       || s6_mode_ff == pf25519_pkg::MODE_SUB))
      |-> (sum_ff[SW-1:258] == '0))
      else $error("add or subtract sum out of range");

endmodule

`default_nettype wire

// ===== tb/sv/prime_field_25519_alu_tb.sv =====
// Self-checking testbench for the GF(2^255-19) add/subtract/multiply/square unit.
// Depends on pf25519_pkg and prime_field_25519_alu; predicts results with wide integers.
`default_nettype none

module prime_field_25519_alu_tb;

   localparam logic [255:0] MODULUS = {1'b0, {247{1'b1}}, 8'hED};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic [1:0]   req_mode = pf25519_pkg::MODE_ADD;
   logic [63:0]  req_a_w0 = '0, req_a_w1 = '0, req_a_w2 = '0, req_a_w3 = '0;
   logic [63:0]  req_b_w0 = '0, req_b_w1 = '0, req_b_w2 = '0, req_b_w3 = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [63:0]  rsp_result_w0, rsp_result_w1, rsp_result_w2;
   logic [62:0]  rsp_result_w3;

   logic [254:0] expected_residues[$];
   int           error_count = 0;
   int           stall_left = 0;
   bit           stall_enable = 1'b1;

   prime_field_25519_alu dut (.*);

   always #6 clock = ~clock;

   // Computes the canonical residue that one transaction should produce.
   function automatic logic [254:0] field_result(pf25519_pkg::mode_type mode,
                                                 logic [255:0] a, logic [255:0] b);
      logic [511:0] wide_a, wide_b, wide_p, wide_r;
      wide_a = {256'd0, a} % {256'd0, MODULUS};
      wide_b = {256'd0, b} % {256'd0, MODULUS};
      wide_p = {256'd0, MODULUS};
      case (mode)
         pf25519_pkg::MODE_ADD: wide_r = (wide_a + wide_b) % wide_p;
         pf25519_pkg::MODE_SUB: wide_r = (wide_a + wide_p - wide_b) % wide_p;
         pf25519_pkg::MODE_MUL: wide_r = (wide_a * wide_b) % wide_p;
         default:               wide_r = (wide_a * wide_a) % wide_p;
      endcase
      return wide_r[254:0];
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // Sends one transaction, predicting its result when it is accepted.
   task automatic send_item(pf25519_pkg::mode_type mode, logic [255:0] a, logic [255:0] b,
                            bit gaps);
      int idle;
      idle = gaps ? gap_length() : 0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      {req_a_w3, req_a_w2, req_a_w1, req_a_w0} <= a;
      {req_b_w3, req_b_w2, req_b_w1, req_b_w0} <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_residues.push_back(field_result(mode, a, b));
   endtask

   function automatic logic [255:0] random_word();
      logic [255:0] v;
      for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
      return v;
   endfunction

   // Picks operands biased toward the modulus and other edges.
   function automatic logic [255:0] random_operand();
      case ($urandom_range(0, 7))
         0: return MODULUS + $urandom_range(0, 40) - 20;
         1: return {256{1'b1}} - $urandom_range(0, 40);
         2: return $urandom_range(0, 40);
         3: return random_word() >> $urandom_range(0, 255);
         default: return random_word();
      endcase
   endfunction

   // Result stall generator: mostly short stalls, now and then a long one.
   always @(posedge clock) begin
      if (!stall_enable) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      logic [254:0] want;
      logic [255:0] got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {1'b0, rsp_result_w3, rsp_result_w2, rsp_result_w1, rsp_result_w0};
         if (expected_residues.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
         end else begin
            want = expected_residues.pop_front();
            if (rsp_result_w0 !== want[63:0]) begin
               $display("%0t: result_w0 expected %h actual %h", $time, want[63:0],
                        rsp_result_w0);
               error_count++;
            end
            if (rsp_result_w1 !== want[127:64]) begin
               $display("%0t: result_w1 expected %h actual %h", $time, want[127:64],
                        rsp_result_w1);
               error_count++;
            end
            if (rsp_result_w2 !== want[191:128]) begin
               $display("%0t: result_w2 expected %h actual %h", $time, want[191:128],
                        rsp_result_w2);
               error_count++;
            end
            if (rsp_result_w3 !== want[254:192]) begin
               $display("%0t: result_w3 expected %h actual %h", $time, want[254:192],
                        rsp_result_w3);
               error_count++;
            end
         end
      end
   end

   // Edge operands in every mode, back to back.
   task automatic test_directed();
      logic [255:0] ones, pm1;
      ones = {256{1'b1}};
      pm1 = MODULUS - 1;
      for (int m = 0; m < 4; m++) begin
         send_item(pf25519_pkg::mode_type'(m), 256'd0, 256'd0, 1'b0);
         send_item(pf25519_pkg::mode_type'(m), ones, ones, 1'b0);
         send_item(pf25519_pkg::mode_type'(m), MODULUS, pm1, 1'b0);
         send_item(pf25519_pkg::mode_type'(m), pm1, ones, 1'b0);
         send_item(pf25519_pkg::mode_type'(m), 256'd1, MODULUS + 1, 1'b0);
      end
      // Subtraction below zero and squaring with a nonzero b.
      send_item(pf25519_pkg::MODE_SUB, 256'd3, 256'd5, 1'b0);
      send_item(pf25519_pkg::MODE_SQR, ones, 256'd12345, 1'b0);
   endtask

   // Random transactions with gaps on both channels.
   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_item(pf25519_pkg::mode_type'($urandom_range(0, 3)), random_operand(),
                   random_operand(), 1'b1);
   endtask

   // Full-rate stretch without any idling.
   task automatic test_full_rate(int count);
      stall_enable = 1'b0;
      for (int i = 0; i < count; i++)
         send_item(pf25519_pkg::mode_type'($urandom_range(0, 3)), random_word(),
                   random_word(), 1'b0);
      stall_enable = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(700);
      test_full_rate(200);
      test_random(528);
      req_valid <= 1'b0;
      while (expected_residues.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a hung pipeline.
   initial begin
      #10000000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
